// ----- rtl/ncrp_pkg.sv -----
// ----------------------------------------------------------------------------
// Name/count record parser package
// Result codes, byte constants and byte classification helpers.
// ----------------------------------------------------------------------------
package ncrp_pkg;

    // Default limit on name bytes before the name counts as too long.
    localparam int NAME_CAPACITY_DEFAULT = 64;

    // Field widths of one result transaction.
    localparam int BYTE_W  = 8;
    localparam int KIND_W  = 2;
    localparam int COUNT_W = 40;
    localparam int LEN_W   = 6;
    localparam int ERR_W   = 3;

    // Packed result data width, rounded up to whole bytes.
    localparam int DATA_BITS = BYTE_W + COUNT_W + LEN_W + ERR_W;
    localparam int DATA_W    = ((DATA_BITS + 7) / 8) * 8;

    // Largest count value; the count saturates here.
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // Special bytes of the line format.
    localparam logic [BYTE_W-1:0] CHAR_COMMA   = 8'h2C;
    localparam logic [BYTE_W-1:0] CHAR_SPACE   = 8'h20;
    localparam logic [BYTE_W-1:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [BYTE_W-1:0] CHAR_ZERO    = 8'h30;
    localparam logic [BYTE_W-1:0] CHAR_NINE    = 8'h39;

    // Result kind codes.
    typedef enum logic [KIND_W-1:0] {
        KIND_CONSUMED = 2'd0,
        KIND_NAME     = 2'd1,
        KIND_RECORD   = 2'd2,
        KIND_ERROR    = 2'd3
    } kind_t;

    // Error codes reported with an error result.
    typedef enum logic [ERR_W-1:0] {
        ERR_NONE      = 3'd0,
        ERR_NO_COMMA  = 3'd1,
        ERR_BAD_CHAR  = 3'd2,
        ERR_TOO_LONG  = 3'd3,
        ERR_NO_DIGIT  = 3'd4,
        ERR_TRAILER   = 3'd5
    } err_code_t;

    // One result transaction before packing.
    typedef struct packed {
        kind_t                kind;
        logic [BYTE_W-1:0]    name_char;
        logic [COUNT_W-1:0]   count_value;
        logic [LEN_W-1:0]     name_length;
        err_code_t            error_code;
    } result_t;

    // True for a decimal digit byte.
    function automatic logic is_digit(input logic [BYTE_W-1:0] b);
        return (b >= CHAR_ZERO) && (b <= CHAR_NINE);
    endfunction

    // True for a byte allowed in a name: letters and space.
    function automatic logic is_name_byte(input logic [BYTE_W-1:0] b);
        return ((b >= 8'h41) && (b <= 8'h5A)) ||
               ((b >= 8'h61) && (b <= 8'h7A)) ||
               (b == CHAR_SPACE);
    endfunction

endpackage

// ----- rtl/name_count_record_parser.sv -----
// ----------------------------------------------------------------------------
// Name/count record parser
// Parses "name,digits\n" lines one byte per transaction into results.
// ----------------------------------------------------------------------------
// Usage:
//   The slave channel (s_tvalid, s_tready, s_tdata) takes one raw byte per
//   transaction. Every byte yields exactly one result on the master channel
//   (m_tvalid, m_tready, m_tdata, m_tuser): m_tuser holds the kind (consumed,
//   name byte, record complete, error), m_tdata the payload fields.
//   Each result is registered in the output register or the skid register.
//   Throughput: one byte per cycle while s_tready is high, as the whole line
//   state (phase, name length, error flag and count register) updates per byte.
//   The count update is one shift-add of the 40-bit count plus a compare.
//   When the receiver stalls, the output register holds its result and one
//   more result is caught in a skid register; s_tready then drops until the
//   output drains. No transaction is lost or repeated.
//   Reset (aresetn low, synchronous) empties both result registers and
//   puts the parser at the start of a name field with all counts cleared.
// ----------------------------------------------------------------------------
module name_count_record_parser #(
    parameter int NAME_CAPACITY = ncrp_pkg::NAME_CAPACITY_DEFAULT
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // Input byte stream
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [ncrp_pkg::BYTE_W-1:0]  s_tdata,   // [7:0] in_byte
    // Result stream
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // [7:0] name_char, [47:8] count_value, [53:48] name_length,
    // [56:54] error_code, [63:57] zero
    output logic [ncrp_pkg::DATA_W-1:0]  m_tdata,
    output logic [ncrp_pkg::KIND_W-1:0]  m_tuser    // [1:0] kind
);

    localparam int NB_W    = $clog2(NAME_CAPACITY + 1);
    localparam int COUNT_W = ncrp_pkg::COUNT_W;
    localparam int LEN_W   = ncrp_pkg::LEN_W;
    localparam int WIDE_W  = COUNT_W + 4;
    localparam int PAD_W   = ncrp_pkg::DATA_W - ncrp_pkg::DATA_BITS;

    typedef enum logic [1:0] {
        PH_NAME   = 2'd0,
        PH_FIRST  = 2'd1,
        PH_DIGITS = 2'd2,
        PH_DROP   = 2'd3
    } phase_t;

    phase_t                 phase_reg, phase_next;
    logic [NB_W-1:0]        name_bytes_reg, name_bytes_next;
    logic                   bad_name_reg, bad_name_next;
    logic [COUNT_W-1:0]     count_reg, count_next;

    logic                   out_valid_reg, out_valid_next;
    ncrp_pkg::result_t      out_data_reg, out_data_next;
    logic                   skid_valid_reg, skid_valid_next;
    ncrp_pkg::result_t      skid_data_reg, skid_data_next;

    ncrp_pkg::result_t      res;
    logic                   accept;
    logic                   out_take;
    logic [3:0]             digit;
    logic [WIDE_W-1:0]      count_wide;
    logic [WIDE_W-1:0]      count_times_ten;
    logic [NB_W+LEN_W-1:0]  name_bytes_ext;

    assign s_tready = !skid_valid_reg;
    assign accept   = s_tvalid && s_tready;
    assign out_take = out_valid_reg && m_tready;

    // Count times ten plus the new digit, wide enough to detect overflow.
    assign digit           = 4'(s_tdata - ncrp_pkg::CHAR_ZERO);
    assign count_times_ten = (WIDE_W'(count_reg) << 3) + (WIDE_W'(count_reg) << 1);
    assign count_wide      = count_times_ten + WIDE_W'(digit);

    // The reported length keeps the low bits of the name byte count.
    assign name_bytes_ext = {{LEN_W{1'b0}}, name_bytes_reg};

    // Line parser: result for the current byte and the next line state.
    always_comb begin
        res             = '0;
        res.kind        = ncrp_pkg::KIND_CONSUMED;
        res.error_code  = ncrp_pkg::ERR_NONE;
        phase_next      = phase_reg;
        name_bytes_next = name_bytes_reg;
        bad_name_next   = bad_name_reg;
        count_next      = count_reg;

        unique case (phase_reg)
            PH_NAME: begin
                if (s_tdata == ncrp_pkg::CHAR_COMMA) begin
                    if (bad_name_reg) begin
                        res.kind       = ncrp_pkg::KIND_ERROR;
                        res.error_code = ncrp_pkg::ERR_BAD_CHAR;
                        phase_next     = PH_DROP;
                    end else if (name_bytes_reg == NB_W'(NAME_CAPACITY)) begin
                        res.kind       = ncrp_pkg::KIND_ERROR;
                        res.error_code = ncrp_pkg::ERR_TOO_LONG;
                        phase_next     = PH_DROP;
                    end else begin
                        phase_next = PH_FIRST;
                    end
                end else if (s_tdata == ncrp_pkg::CHAR_NEWLINE) begin
                    res.kind       = ncrp_pkg::KIND_ERROR;
                    res.error_code = ncrp_pkg::ERR_NO_COMMA;
                    phase_next     = PH_NAME;
                end else begin
                    // Count every name byte, saturating at the capacity.
                    if (name_bytes_reg < NB_W'(NAME_CAPACITY)) begin
                        name_bytes_next = name_bytes_reg + NB_W'(1);
                    end
                    if (ncrp_pkg::is_name_byte(s_tdata)) begin
                        res.kind      = ncrp_pkg::KIND_NAME;
                        res.name_char = s_tdata;
                    end else begin
                        bad_name_next = 1'b1;
                    end
                end
            end
            PH_FIRST: begin
                if (ncrp_pkg::is_digit(s_tdata)) begin
                    count_next = COUNT_W'(digit);
                    phase_next = PH_DIGITS;
                end else begin
                    res.kind       = ncrp_pkg::KIND_ERROR;
                    res.error_code = ncrp_pkg::ERR_NO_DIGIT;
                    phase_next     = (s_tdata == ncrp_pkg::CHAR_NEWLINE) ? PH_NAME : PH_DROP;
                end
            end
            PH_DIGITS: begin
                if (ncrp_pkg::is_digit(s_tdata)) begin
                    if (count_wide > WIDE_W'(ncrp_pkg::COUNT_MAX)) begin
                        count_next = ncrp_pkg::COUNT_MAX;
                    end else begin
                        count_next = count_wide[COUNT_W-1:0];
                    end
                end else if (s_tdata == ncrp_pkg::CHAR_NEWLINE) begin
                    res.kind        = ncrp_pkg::KIND_RECORD;
                    res.count_value = count_reg;
                    res.name_length = name_bytes_ext[LEN_W-1:0];
                    phase_next      = PH_NAME;
                end else begin
                    res.kind       = ncrp_pkg::KIND_ERROR;
                    res.error_code = ncrp_pkg::ERR_TRAILER;
                    phase_next     = PH_DROP;
                end
            end
            PH_DROP: begin
                if (s_tdata == ncrp_pkg::CHAR_NEWLINE) begin
                    phase_next = PH_NAME;
                end
            end
            default: begin
                phase_next = PH_NAME;
            end
        endcase

        // Every line end, and every entry into the drop phase, clears the per-line state.
        if (phase_next != phase_reg && phase_next != PH_FIRST &&
            phase_next != PH_DIGITS) begin
            name_bytes_next = '0;
            bad_name_next   = 1'b0;
            count_next      = '0;
        end else if (phase_reg == PH_NAME && phase_next == PH_NAME &&
                     s_tdata == ncrp_pkg::CHAR_NEWLINE) begin
            name_bytes_next = '0;
            bad_name_next   = 1'b0;
            count_next      = '0;
        end
    end

    // Output register and skid register steering.
    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;

        if (out_take || !out_valid_reg) begin
            if (skid_valid_reg) begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = accept;
                out_data_next  = res;
            end
        end else if (accept) begin
            skid_valid_next = 1'b1;
            skid_data_next  = res;
        end
    end

    // State and result registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_NAME;
            name_bytes_reg <= '0;
            bad_name_reg   <= 1'b0;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                phase_reg      <= phase_next;
                name_bytes_reg <= name_bytes_next;
                bad_name_reg   <= bad_name_next;
                count_reg      <= count_next;
            end
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    // Pack the result transaction.
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_data_reg.kind;
    assign m_tdata  = {{PAD_W{1'b0}},
                       out_data_reg.error_code,
                       out_data_reg.name_length,
                       out_data_reg.count_value,
                       out_data_reg.name_char};

    // The skid register only fills behind a full output register.
    a_skid_behind_out : assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register valid while output register empty");

    // The count register holds a value only while digits are collected.
    a_count_idle_zero : assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg != PH_DIGITS) |-> (count_reg == '0))
        else $error("count register not cleared outside the digit field");

    // The name byte count never passes the capacity.
    a_name_bytes_cap : assert property (@(posedge aclk) disable iff (!aresetn)
        name_bytes_reg <= NB_W'(NAME_CAPACITY))
        else $error("name byte count above capacity");

    // A completed record never carries an error code.
    a_record_no_err : assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_data_reg.kind == ncrp_pkg::KIND_RECORD) |->
        (out_data_reg.error_code == ncrp_pkg::ERR_NONE))
        else $error("record result with nonzero error code");

endmodule
